@@ hw/rtl/mmrm_pkg.sv @@
// Shared types, constants and helpers for the memory map run merger.
package mmrm_pkg;

   localparam int unsigned PAGE_SHIFT = 12;
   localparam int unsigned ADDR_W = 64;
   localparam int unsigned TYPE_W = 32;
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QUEUE_AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned QUEUE_CW = $clog2(QUEUE_DEPTH + 1);

   localparam logic [TYPE_W-1:0] TYPE_LOADER_CODE = 32'd1;
   localparam logic [TYPE_W-1:0] TYPE_LOADER_DATA = 32'd2;
   localparam logic [TYPE_W-1:0] TYPE_BOOT_CODE = 32'd3;
   localparam logic [TYPE_W-1:0] TYPE_BOOT_DATA = 32'd4;
   localparam logic [TYPE_W-1:0] TYPE_CONVENTIONAL = 32'd7;

   typedef struct packed {
      logic [TYPE_W-1:0] in_type;
      logic [ADDR_W-1:0] in_phys_start;
      logic [ADDR_W-1:0] in_virt_start;
      logic [ADDR_W-1:0] in_pages;
      logic [ADDR_W-1:0] in_attr;
      logic in_last;
   } req_type;

   typedef struct packed {
      logic [TYPE_W-1:0] out_type;
      logic [ADDR_W-1:0] out_phys_start;
      logic [ADDR_W-1:0] out_virt_start;
      logic [ADDR_W-1:0] out_pages;
      logic [ADDR_W-1:0] out_attr;
      logic out_last;
   } rsp_type;

   // One queue entry holds every beat that a single input descriptor releases.
   typedef struct packed {
      logic emit_old;
      rsp_type old_desc;
      logic flush;
      rsp_type last_desc;
   } pair_type;

   typedef struct packed {
      logic full;
      logic avail;
   } qstat_type;

   function automatic logic usable_kind(input logic [TYPE_W-1:0] t);
      logic ok;
      case (t) inside
         TYPE_LOADER_CODE, TYPE_LOADER_DATA, TYPE_BOOT_CODE, TYPE_BOOT_DATA,
         TYPE_CONVENTIONAL: ok = 1'b1;
         default: ok = 1'b0;
      endcase
      return ok;
   endfunction

endpackage

@@ hw/rtl/mmrm_front.sv @@
// Front end: holds the pending descriptor, tests each new one for a merge.
module mmrm_front (
   input  logic clock,
   input  logic reset,
   input  logic accept,
   input  mmrm_pkg::req_type req_desc,
   output logic q_push,
   output mmrm_pkg::pair_type q_entry
);

   logic pend_valid_ff, pend_valid_in;
   mmrm_pkg::rsp_type pend_ff, pend_in;

   logic [mmrm_pkg::ADDR_W-1:0] bytes;
   logic [mmrm_pkg::ADDR_W:0] page_sum;
   logic [mmrm_pkg::ADDR_W:0] phys_end;
   logic [mmrm_pkg::ADDR_W:0] virt_end;
   logic size_ok, sum_ok, phys_ok, virt_ok, virt_check, join_ok;

   always_comb begin
      bytes = {pend_ff.out_pages[mmrm_pkg::ADDR_W-mmrm_pkg::PAGE_SHIFT-1:0],
               {mmrm_pkg::PAGE_SHIFT{1'b0}}};
      page_sum = {1'b0, pend_ff.out_pages} + {1'b0, req_desc.in_pages};
      phys_end = {1'b0, pend_ff.out_phys_start} + {1'b0, bytes};
      virt_end = {1'b0, pend_ff.out_virt_start} + {1'b0, bytes};
      size_ok = (pend_ff.out_pages[mmrm_pkg::ADDR_W-1:mmrm_pkg::ADDR_W-mmrm_pkg::PAGE_SHIFT]
                 == '0);
      sum_ok = !page_sum[mmrm_pkg::ADDR_W];
      phys_ok = !phys_end[mmrm_pkg::ADDR_W]
                && (phys_end[mmrm_pkg::ADDR_W-1:0] == req_desc.in_phys_start);
      virt_check = (pend_ff.out_virt_start != '0) || (req_desc.in_virt_start != '0);
      virt_ok = !virt_check || (!virt_end[mmrm_pkg::ADDR_W]
                && (virt_end[mmrm_pkg::ADDR_W-1:0] == req_desc.in_virt_start));
      join_ok = pend_valid_ff
                && mmrm_pkg::usable_kind(pend_ff.out_type)
                && mmrm_pkg::usable_kind(req_desc.in_type)
                && (pend_ff.out_attr == req_desc.in_attr)
                && size_ok && sum_ok && phys_ok && virt_ok;

      pend_valid_in = pend_valid_ff;
      pend_in = pend_ff;
      if (join_ok) begin
         pend_in.out_type = mmrm_pkg::TYPE_CONVENTIONAL;
         pend_in.out_pages = page_sum[mmrm_pkg::ADDR_W-1:0];
      end else begin
         pend_in.out_type = req_desc.in_type;
         pend_in.out_phys_start = req_desc.in_phys_start;
         pend_in.out_virt_start = req_desc.in_virt_start;
         pend_in.out_pages = req_desc.in_pages;
         pend_in.out_attr = req_desc.in_attr;
      end
      pend_in.out_last = 1'b0;
      if (accept) begin
         pend_valid_in = !req_desc.in_last;
      end

      q_entry.emit_old = pend_valid_ff && !join_ok;
      q_entry.old_desc = pend_ff;
      q_entry.old_desc.out_last = 1'b0;
      q_entry.flush = req_desc.in_last;
      q_entry.last_desc = pend_in;
      q_entry.last_desc.out_last = 1'b1;
      q_push = accept && (q_entry.emit_old || req_desc.in_last);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
      end
      if (accept) begin
         pend_ff <= pend_in;
      end
   end

endmodule

@@ hw/rtl/mmrm_queue.sv @@
// Short queue of result pairs between the merge front end and the output stage.
module mmrm_queue (
   input  logic clock,
   input  logic reset,
   input  logic push,
   input  mmrm_pkg::pair_type wr_entry,
   input  logic pop,
   output mmrm_pkg::pair_type rd_entry,
   output mmrm_pkg::qstat_type stat
);

   mmrm_pkg::pair_type mem_ff [mmrm_pkg::QUEUE_DEPTH];
   logic [mmrm_pkg::QUEUE_AW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [mmrm_pkg::QUEUE_CW-1:0] count_ff, count_in;
   logic do_push, do_pop;

   localparam logic [mmrm_pkg::QUEUE_AW-1:0] LAST_SLOT =
      mmrm_pkg::QUEUE_AW'(mmrm_pkg::QUEUE_DEPTH - 1);
   localparam logic [mmrm_pkg::QUEUE_CW-1:0] FULL_COUNT =
      mmrm_pkg::QUEUE_CW'(mmrm_pkg::QUEUE_DEPTH);

   always_comb begin
      stat.full = (count_ff == FULL_COUNT);
      stat.avail = (count_ff != '0);
      do_push = push && !stat.full;
      do_pop = pop && stat.avail;
      rd_entry = mem_ff[rd_ptr_ff];
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_entry;
      end
   end

endmodule

@@ hw/rtl/mmrm_back.sv @@
// Output stage: takes result pairs from the queue and presents them one beat at a time.
module mmrm_back (
   input  logic clock,
   input  logic reset,
   input  mmrm_pkg::qstat_type q_stat,
   input  mmrm_pkg::pair_type q_entry,
   output logic q_pop,
   input  logic pop,
   output logic empty,
   output mmrm_pkg::rsp_type rsp_desc
);

   mmrm_pkg::pair_type cur_ff, cur_in;
   logic cur_valid_ff, cur_valid_in;
   logic sel_ff, sel_in;
   logic finishing, take;

   always_comb begin
      empty = !cur_valid_ff;
      rsp_desc = sel_ff ? cur_ff.last_desc : cur_ff.old_desc;
      finishing = sel_ff || !cur_ff.flush;
      take = !cur_valid_ff || (pop && finishing);
      q_pop = take && q_stat.avail;

      cur_in = cur_ff;
      cur_valid_in = cur_valid_ff;
      sel_in = sel_ff;
      if (take) begin
         cur_in = q_entry;
         cur_valid_in = q_stat.avail;
         sel_in = !q_entry.emit_old;
      end else if (pop) begin
         sel_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         sel_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         sel_ff <= sel_in;
      end
      if (take) begin
         cur_ff <= cur_in;
      end
   end

endmodule

@@ hw/rtl/memory_map_run_merger_core.sv @@
// Top level of the memory map run merger: front end, pair queue and output stage.
//
//  channel   ports                         beat moves when
//  request   push, full, req_desc          push && !full
//  response  empty, pop, rsp_desc          pop && !empty
//
// A descriptor is taken in every cycle while the pair queue has room; the merge
// test and pending update finish in that same cycle.
// Its results are registered in the pair queue and then in the output stage before they reach the response ports.
// A descriptor that releases two results holds the output stage for two beats.
// Reset is synchronous and leaves no pending descriptor and an empty queue.
// A stalled response side fills the two-entry queue and then raises full.
module memory_map_run_merger_core (
   input  logic clock,
   input  logic reset,
   input  logic push,
   output logic full,
   input  mmrm_pkg::req_type req_desc,
   output logic empty,
   input  logic pop,
   output mmrm_pkg::rsp_type rsp_desc
);

   logic accept;
   logic q_push, q_pop;
   mmrm_pkg::pair_type q_wr_entry, q_rd_entry;
   mmrm_pkg::qstat_type q_stat;

   assign full = q_stat.full;
   assign accept = push && !q_stat.full;

   mmrm_front u_front (
      .clock(clock),
      .reset(reset),
      .accept(accept),
      .req_desc(req_desc),
      .q_push(q_push),
      .q_entry(q_wr_entry)
   );

   mmrm_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push(q_push),
      .wr_entry(q_wr_entry),
      .pop(q_pop),
      .rd_entry(q_rd_entry),
      .stat(q_stat)
   );

   mmrm_back u_back (
      .clock(clock),
      .reset(reset),
      .q_stat(q_stat),
      .q_entry(q_rd_entry),
      .q_pop(q_pop),
      .pop(pop),
      .empty(empty),
      .rsp_desc(rsp_desc)
   );

   a_last_queued: assert property (@(posedge clock) disable iff (reset)
      (accept && req_desc.in_last) |-> q_push)
      else $error("final descriptor did not queue a flush");

   a_queue_sane: assert property (@(posedge clock) disable iff (reset)
      !(q_stat.full && !q_stat.avail))
      else $error("queue full while holding nothing");

   a_pop_needs_data: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_stat.avail)
      else $error("output stage took from an empty queue");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> empty)
      else $error("response side not empty after reset");

endmodule
